// ===== src/wmpt_pkg.sv =====
// ----------------------------------------------------------------------------
// wmpt_pkg
// Shared widths, register indexes, reset values and stage enable type for the
// world/map pose transform.
// ----------------------------------------------------------------------------
package wmpt_pkg;

  localparam int POS_WIDTH_DEF = 32;

  localparam int FIELD_W    = 32;
  localparam int ANGLE_W    = 16;
  localparam int TRIG_W     = 16;
  localparam int SCALE_W    = 31;
  localparam int TRIG_FRAC  = 14;
  localparam int SCALE_FRAC = 16;
  localparam int ANG_SUM_W  = ANGLE_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ANGLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COS_ANGLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_ANGLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_RECIP = 3'd6;

  localparam logic FUNC_W2M = 1'b0;
  localparam logic FUNC_M2W = 1'b1;

  localparam logic signed [ANG_SUM_W-1:0] PI_Q13     = 18'sd25736;
  localparam logic signed [ANG_SUM_W-1:0] TWO_PI_Q13 = 18'sd51472;

  localparam logic signed [TRIG_W-1:0] COS_RESET   = 16'sd16384;
  localparam logic [SCALE_W-1:0]       SCALE_RESET = 31'd65536;

  typedef struct packed {
    logic stage_a;
    logic stage_b;
  } stage_en_t;

endpackage

// ===== src/wmpt_scale.sv =====
// ----------------------------------------------------------------------------
// wmpt_scale
// Two-stage unsigned Q15.16 scaling of a point: registered products, then registered
// floor shift by the fraction width.
// ----------------------------------------------------------------------------
module wmpt_scale
  import wmpt_pkg::*;
#(
  parameter int IW = 33
) (
  input  logic                                     clk,
  input  stage_en_t                                en,
  input  logic signed [IW-1:0]                     u,
  input  logic signed [IW-1:0]                     v,
  input  logic [SCALE_W-1:0]                       k,
  output logic signed [IW+SCALE_W-SCALE_FRAC:0]    su,
  output logic signed [IW+SCALE_W-SCALE_FRAC:0]    sv
);

  localparam int PW = IW + SCALE_W + 1;

  logic signed [PW-1:0] pu;
  logic signed [PW-1:0] pv;

  always_ff @(posedge clk) begin
    if (en.stage_a) begin
      pu <= u * $signed({1'b0, k});
      pv <= v * $signed({1'b0, k});
    end
    if (en.stage_b) begin
      su <= pu[PW-1:SCALE_FRAC];
      sv <= pv[PW-1:SCALE_FRAC];
    end
  end

endmodule

// ===== src/wmpt_rotate.sv =====
// ----------------------------------------------------------------------------
// wmpt_rotate
// Two-stage Q1.14 rotation of a point by the map angle, or by its negative
// when INVERSE is set: registered products, then registered sum and floor
// shift.
// ----------------------------------------------------------------------------
module wmpt_rotate
  import wmpt_pkg::*;
#(
  parameter int   IW      = 32,
  parameter logic INVERSE = 1'b0
) (
  input  logic                                  clk,
  input  stage_en_t                             en,
  input  logic signed [IW-1:0]                  u,
  input  logic signed [IW-1:0]                  v,
  input  logic signed [TRIG_W-1:0]              c,
  input  logic signed [TRIG_W-1:0]              s,
  output logic signed [IW+TRIG_W-TRIG_FRAC:0]   ru,
  output logic signed [IW+TRIG_W-TRIG_FRAC:0]   rv
);

  localparam int PW = IW + TRIG_W;

  logic signed [PW-1:0] cu;
  logic signed [PW-1:0] sv_p;
  logic signed [PW-1:0] su_p;
  logic signed [PW-1:0] cv;
  logic signed [PW:0]   ru_sum;
  logic signed [PW:0]   rv_sum;

  always_ff @(posedge clk) begin
    if (en.stage_a) begin
      cu   <= c * u;
      sv_p <= s * v;
      su_p <= s * u;
      cv   <= c * v;
    end
  end

  always_comb begin
    if (INVERSE) begin
      ru_sum = (PW+1)'(cu) + (PW+1)'(sv_p);
      rv_sum = (PW+1)'(cv) - (PW+1)'(su_p);
    end else begin
      ru_sum = (PW+1)'(cu) - (PW+1)'(sv_p);
      rv_sum = (PW+1)'(su_p) + (PW+1)'(cv);
    end
  end

  always_ff @(posedge clk) begin
    if (en.stage_b) begin
      ru <= ru_sum[PW:TRIG_FRAC];
      rv <= rv_sum[PW:TRIG_FRAC];
    end
  end

endmodule

// ===== src/world_map_pose_transform.sv =====
// ----------------------------------------------------------------------------
// world_map_pose_transform
// Fixed-point pose conversion between world frame and occupancy-map frame.
// ----------------------------------------------------------------------------
// Takes one pose per clock unless the pipeline is full and the output is
// stalled. The pipeline has a capture stage (origin subtract for world to
// map, heading add or subtract and wrap), two stages of scaling multipliers,
// two stages of rotation multipliers, in the order the direction needs, and
// an output stage that adds the origin for map to world and saturates to
// POS_WIDTH bits. Bubbles are squeezed out while the output is stalled.
// Configuration writes take effect at once and belong between transactions.
// ----------------------------------------------------------------------------
module world_map_pose_transform
  import wmpt_pkg::*;
#(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,

  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        func,
  input  logic signed [FIELD_W-1:0]   x_in,
  input  logic signed [FIELD_W-1:0]   y_in,
  input  logic signed [ANGLE_W-1:0]   angle_in,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [FIELD_W-1:0]   x_out,
  output logic signed [FIELD_W-1:0]   y_out,
  output logic signed [ANGLE_W-1:0]   angle_out
);

  localparam int STAGES  = 6;
  localparam int LAST    = STAGES - 1;
  localparam int D_W     = FIELD_W + 1;
  localparam int WS_W    = D_W + SCALE_W + 1 - SCALE_FRAC;
  localparam int WR_W    = WS_W + TRIG_W + 1 - TRIG_FRAC;
  localparam int MR_W    = FIELD_W + TRIG_W + 1 - TRIG_FRAC;
  localparam int MS_W    = MR_W + SCALE_W + 1 - SCALE_FRAC;
  localparam int SAT_W   = WR_W + 1;
  localparam logic signed [SAT_W-1:0] SAT_HI = (SAT_W'(1) <<< (POS_WIDTH - 1)) - SAT_W'(1);
  localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [FIELD_W-1:0] origin_x;
  logic signed [FIELD_W-1:0] origin_y;
  logic signed [ANGLE_W-1:0] map_angle;
  logic signed [TRIG_W-1:0]  cos_angle;
  logic signed [TRIG_W-1:0]  sin_angle;
  logic [SCALE_W-1:0]        cell_size;
  logic [SCALE_W-1:0]        cell_size_recip;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x        <= '0;
      origin_y        <= '0;
      map_angle       <= '0;
      cos_angle       <= COS_RESET;
      sin_angle       <= '0;
      cell_size       <= SCALE_RESET;
      cell_size_recip <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:   origin_x        <= cfg_data[FIELD_W-1:0];
        REG_ORIGIN_Y:   origin_y        <= cfg_data[FIELD_W-1:0];
        REG_MAP_ANGLE:  map_angle       <= cfg_data[ANGLE_W-1:0];
        REG_COS_ANGLE:  cos_angle       <= cfg_data[TRIG_W-1:0];
        REG_SIN_ANGLE:  sin_angle       <= cfg_data[TRIG_W-1:0];
        REG_CELL_SIZE:  cell_size       <= cfg_data[SCALE_W-1:0];
        REG_CELL_RECIP: cell_size_recip <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;

  always_comb begin
    en[LAST] = !v[LAST] || !out_stall;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[LAST];

  // capture stage
  logic signed [ANG_SUM_W-1:0] ang_sum;
  logic signed [ANG_SUM_W-1:0] ang_wrap;

  always_comb begin
    if (func == FUNC_M2W) begin
      ang_sum = ANG_SUM_W'(angle_in) + ANG_SUM_W'(map_angle);
    end else begin
      ang_sum = ANG_SUM_W'(angle_in) - ANG_SUM_W'(map_angle);
    end
    if (ang_sum >= PI_Q13) begin
      ang_wrap = ang_sum - TWO_PI_Q13;
    end else if (ang_sum < -PI_Q13) begin
      ang_wrap = ang_sum + TWO_PI_Q13;
    end else begin
      ang_wrap = ang_sum;
    end
  end

  logic signed [D_W-1:0]     dx;
  logic signed [D_W-1:0]     dy;
  logic signed [FIELD_W-1:0] px;
  logic signed [FIELD_W-1:0] py;
  logic                      func_q [LAST];
  logic signed [ANGLE_W-1:0] ang_q  [LAST];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx        <= D_W'(x_in) - D_W'(origin_x);
      dy        <= D_W'(y_in) - D_W'(origin_y);
      px        <= x_in;
      py        <= y_in;
      func_q[0] <= func;
      ang_q[0]  <= ang_wrap[ANGLE_W-1:0];
    end
    for (int k = 1; k < LAST; k++) begin
      if (en[k]) begin
        func_q[k] <= func_q[k-1];
        ang_q[k]  <= ang_q[k-1];
      end
    end
  end

  stage_en_t en_first;
  stage_en_t en_second;

  assign en_first  = '{stage_a: en[1], stage_b: en[2]};
  assign en_second = '{stage_a: en[3], stage_b: en[4]};

  // world to map: scale, then rotate by minus the map angle
  logic signed [WS_W-1:0] w_sx;
  logic signed [WS_W-1:0] w_sy;
  logic signed [WR_W-1:0] w_rx;
  logic signed [WR_W-1:0] w_ry;

  wmpt_scale #(.IW(D_W)) u_w2m_scale (
    .clk (clk),
    .en  (en_first),
    .u   (dx),
    .v   (dy),
    .k   (cell_size_recip),
    .su  (w_sx),
    .sv  (w_sy)
  );

  wmpt_rotate #(.IW(WS_W), .INVERSE(1'b1)) u_w2m_rotate (
    .clk (clk),
    .en  (en_second),
    .u   (w_sx),
    .v   (w_sy),
    .c   (cos_angle),
    .s   (sin_angle),
    .ru  (w_rx),
    .rv  (w_ry)
  );

  // map to world: rotate by the map angle, then scale
  logic signed [MR_W-1:0] m_rx;
  logic signed [MR_W-1:0] m_ry;
  logic signed [MS_W-1:0] m_sx;
  logic signed [MS_W-1:0] m_sy;

  wmpt_rotate #(.IW(FIELD_W), .INVERSE(1'b0)) u_m2w_rotate (
    .clk (clk),
    .en  (en_first),
    .u   (px),
    .v   (py),
    .c   (cos_angle),
    .s   (sin_angle),
    .ru  (m_rx),
    .rv  (m_ry)
  );

  wmpt_scale #(.IW(MR_W)) u_m2w_scale (
    .clk (clk),
    .en  (en_second),
    .u   (m_rx),
    .v   (m_ry),
    .k   (cell_size),
    .su  (m_sx),
    .sv  (m_sy)
  );

  // output stage
  logic signed [SAT_W-1:0] pre_x;
  logic signed [SAT_W-1:0] pre_y;
  logic signed [SAT_W-1:0] sat_x;
  logic signed [SAT_W-1:0] sat_y;

  always_comb begin
    if (func_q[LAST-1] == FUNC_M2W) begin
      pre_x = SAT_W'(m_sx) + SAT_W'(origin_x);
      pre_y = SAT_W'(m_sy) + SAT_W'(origin_y);
    end else begin
      pre_x = SAT_W'(w_rx);
      pre_y = SAT_W'(w_ry);
    end
    if (pre_x > SAT_HI) begin
      sat_x = SAT_HI;
    end else if (pre_x < SAT_LO) begin
      sat_x = SAT_LO;
    end else begin
      sat_x = pre_x;
    end
    if (pre_y > SAT_HI) begin
      sat_y = SAT_HI;
    end else if (pre_y < SAT_LO) begin
      sat_y = SAT_LO;
    end else begin
      sat_y = pre_y;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      x_out     <= sat_x[FIELD_W-1:0];
      y_out     <= sat_y[FIELD_W-1:0];
      angle_out <= ang_q[LAST-1];
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&v) && out_stall)
    else $error("input stalled while the pipeline has room");

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> $countones(v) == $past($countones(v))
                             + int'($past(in_valid && !in_stall))
                             - int'($past(out_valid && !out_stall)))
    else $error("pipeline lost or duplicated a transaction");

endmodule

// ===== tb/sv/tb_world_map_pose_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_world_map_pose_transform
// Self-checking bench for the world/map pose transform. A directed set covers
// field extremes, both directions, heading wrap and out-of-range headings, and
// zero and minimum scales. Random phases follow under changing register
// settings and idling patterns. Every output transaction is compared field by
// field with a bit-exact fixed-point prediction made at input acceptance.
// ----------------------------------------------------------------------------
module tb_world_map_pose_transform
  import wmpt_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_POSES  = 112;
  localparam int MAX_REPORTS  = 10;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  localparam logic signed [95:0] POS_MAX = (96'sd1 <<< (POS_WIDTH_DEF - 1)) - 96'sd1;
  localparam logic signed [95:0] POS_MIN = -POS_MAX - 96'sd1;

  typedef struct {
    logic                      fn;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [ANGLE_W-1:0] ang;
  } pose_t;

  typedef struct {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [ANGLE_W-1:0] ang;
  } map_pose_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data  = '0;
  logic                      in_valid  = 1'b0;
  logic                      func      = FUNC_W2M;
  logic signed [FIELD_W-1:0] x_in      = '0;
  logic signed [FIELD_W-1:0] y_in      = '0;
  logic signed [ANGLE_W-1:0] angle_in  = '0;
  logic                      out_stall = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  logic signed [FIELD_W-1:0] x_out;
  logic signed [FIELD_W-1:0] y_out;
  logic signed [ANGLE_W-1:0] angle_out;

  // register shadow, starts at reset values
  logic signed [FIELD_W-1:0] org_x    = '0;
  logic signed [FIELD_W-1:0] org_y    = '0;
  logic signed [ANGLE_W-1:0] map_ang  = '0;
  logic signed [TRIG_W-1:0]  cos_v    = COS_RESET;
  logic signed [TRIG_W-1:0]  sin_v    = '0;
  logic [SCALE_W-1:0]        cell_sz  = SCALE_RESET;
  logic [SCALE_W-1:0]        cell_rcp = SCALE_RESET;

  pose_t     pending_poses[$];
  map_pose_t expected_poses[$];

  logic in_fire        = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   poses_queued   = 0;
  int   poses_checked  = 0;
  int   mismatches     = 0;
  int   settings       = 1;
  int   cycles         = 0;

  world_map_pose_transform u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .x_in      (x_in),
    .y_in      (y_in),
    .angle_in  (angle_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_out     (x_out),
    .y_out     (y_out),
    .angle_out (angle_out)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [FIELD_W-1:0] saturate_pos(logic signed [95:0] v);
    logic signed [95:0] c;
    c = v;
    if (v > POS_MAX) c = POS_MAX;
    else if (v < POS_MIN) c = POS_MIN;
    return c[FIELD_W-1:0];
  endfunction

  function automatic map_pose_t transform_pose(pose_t p);
    logic signed [95:0] px, py, ux, uy, vx, vy, cell_s, rcp_s;
    logic signed [ANG_SUM_W-1:0] a;
    map_pose_t r;
    px     = p.x;
    py     = p.y;
    cell_s = $signed({1'b0, cell_sz});
    rcp_s  = $signed({1'b0, cell_rcp});
    if (p.fn == FUNC_W2M) begin
      ux = ((px - org_x) * rcp_s) >>> SCALE_FRAC;
      uy = ((py - org_y) * rcp_s) >>> SCALE_FRAC;
      vx = (cos_v * ux + sin_v * uy) >>> TRIG_FRAC;
      vy = (cos_v * uy - sin_v * ux) >>> TRIG_FRAC;
      a  = p.ang - map_ang;
    end else begin
      ux = (cos_v * px - sin_v * py) >>> TRIG_FRAC;
      uy = (sin_v * px + cos_v * py) >>> TRIG_FRAC;
      vx = ((ux * cell_s) >>> SCALE_FRAC) + org_x;
      vy = ((uy * cell_s) >>> SCALE_FRAC) + org_y;
      a  = p.ang + map_ang;
    end
    if (a >= PI_Q13) a = a - TWO_PI_Q13;
    else if (a < -PI_Q13) a = a + TWO_PI_Q13;
    r.x   = saturate_pos(vx);
    r.y   = saturate_pos(vy);
    r.ang = a[ANGLE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [FIELD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(32'h00FFFFFF)) - 32'sh00800000;
      2: return $signed($urandom_range(32'h0003FFFF)) - 32'sh00020000;
      default: begin
        case ($urandom_range(3))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [ANGLE_W-1:0] rand_heading();
    int t;
    if ($urandom_range(9) == 0) t = $urandom;
    else t = int'($urandom_range(51472)) - 25736;
    return t[ANGLE_W-1:0];
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    logic [31:0] u;
    u = $urandom;
    if ($urandom_range(3) == 0) return u[SCALE_W-1:0];
    return SCALE_W'($urandom_range(32'h00100000, 32'h00000400));
  endfunction

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ORIGIN_X:   org_x    = val;
      REG_ORIGIN_Y:   org_y    = val;
      REG_MAP_ANGLE:  map_ang  = val[ANGLE_W-1:0];
      REG_COS_ANGLE:  cos_v    = val[TRIG_W-1:0];
      REG_SIN_ANGLE:  sin_v    = val[TRIG_W-1:0];
      REG_CELL_SIZE:  cell_sz  = val[SCALE_W-1:0];
      REG_CELL_RECIP: cell_rcp = val[SCALE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pose(logic fn, logic signed [FIELD_W-1:0] x,
                            logic signed [FIELD_W-1:0] y, logic signed [ANGLE_W-1:0] ang);
    pose_t p;
    p.fn  = fn;
    p.x   = x;
    p.y   = y;
    p.ang = ang;
    pending_poses.push_back(p);
    poses_queued++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    while (poses_checked != poses_queued) @(negedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // driver: advance on acceptance, hold while stalled
  always @(negedge clk) begin : driver
    pose_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_poses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_poses.pop_front();
        in_valid <= 1'b1;
        func     <= nxt.fn;
        x_in     <= nxt.x;
        y_in     <= nxt.y;
        angle_in <= nxt.ang;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    map_pose_t want;
    pose_t     seen;
    in_fire <= in_valid && !in_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected transaction: x %0d y %0d angle %0d",
                     x_out, y_out, angle_out);
        end else begin
          want = expected_poses.pop_front();
          poses_checked++;
          if (x_out !== want.x || y_out !== want.y || angle_out !== want.ang) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch #%0d: exp x %0d y %0d angle %0d, got x %0d y %0d angle %0d",
                       poses_checked, want.x, want.y, want.ang, x_out, y_out, angle_out);
          end
        end
      end
      if (in_valid && !in_stall) begin
        seen.fn  = func;
        seen.x   = x_in;
        seen.y   = y_in;
        seen.ang = angle_in;
        expected_poses.push_back(transform_pose(seen));
      end
    end
  end

  initial begin : stimulus
    int ph;
    int k;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values, heading wrap and out-of-range headings
    @(posedge clk);
    set_idling(0, 0);
    queue_pose(FUNC_W2M, 32'sh0, 32'sh0, 16'sd0);
    queue_pose(FUNC_W2M, 32'sh7FFFFFFF, 32'sh80000000, 16'sd25736);
    queue_pose(FUNC_M2W, 32'sh80000000, 32'sh7FFFFFFF, -16'sd25736);
    queue_pose(FUNC_W2M, 32'sd1, -32'sd1, 16'sh7FFF);
    queue_pose(FUNC_M2W, -32'sd1, 32'sd1, 16'sh8000);
    queue_pose(FUNC_M2W, 32'sh00010000, 32'sh00020000, 16'sd12345);
    wait_drain();

    // largest settings, saturation both ways
    set_reg(REG_ORIGIN_X, 32'h7FFFFFFF);
    set_reg(REG_ORIGIN_Y, 32'h80000000);
    set_reg(REG_MAP_ANGLE, 32'sd25736);
    set_reg(REG_COS_ANGLE, -32'sd16384);
    set_reg(REG_SIN_ANGLE, 32'sd16384);
    set_reg(REG_CELL_SIZE, 32'h7FFFFFFF);
    set_reg(REG_CELL_RECIP, 32'h7FFFFFFF);
    settings++;
    @(posedge clk);
    set_idling(88, 0);
    queue_pose(FUNC_W2M, 32'sh80000000, 32'sh7FFFFFFF, -16'sd25736);
    queue_pose(FUNC_M2W, 32'sh7FFFFFFF, 32'sh80000000, 16'sd25736);
    queue_pose(FUNC_W2M, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh8000);
    queue_pose(FUNC_M2W, 32'sh80000000, 32'sh80000000, 16'sh7FFF);
    queue_pose(FUNC_W2M, 32'sh0, 32'sh0, 16'sd0);
    wait_drain();

    // zero scales collapse positions; out-of-range index is dropped
    set_reg(REG_ORIGIN_X, 32'h12345678);
    set_reg(REG_ORIGIN_Y, -32'sh0BADF00D);
    set_reg(REG_MAP_ANGLE, -32'sd25736);
    set_reg(REG_COS_ANGLE, -32'sd16384);
    set_reg(REG_SIN_ANGLE, -32'sd16384);
    set_reg(REG_CELL_SIZE, 32'h0);
    set_reg(REG_CELL_RECIP, 32'h0);
    set_reg(REG_NONE, 32'hFFFFFFFF);
    settings++;
    @(posedge clk);
    set_idling(0, 88);
    queue_pose(FUNC_W2M, 32'sh00400000, -32'sh00400000, 16'sd100);
    queue_pose(FUNC_M2W, 32'sh00400000, -32'sh00400000, -16'sd100);
    queue_pose(FUNC_W2M, 32'sh7FFFFFFF, 32'sh80000000, 16'sd0);
    queue_pose(FUNC_M2W, 32'sh7FFFFFFF, 32'sh80000000, 16'sd0);
    wait_drain();

    // smallest scales
    set_reg(REG_ORIGIN_X, 32'h80000000);
    set_reg(REG_ORIGIN_Y, 32'h7FFFFFFF);
    set_reg(REG_MAP_ANGLE, 32'sd0);
    set_reg(REG_COS_ANGLE, 32'sd16384);
    set_reg(REG_SIN_ANGLE, 32'sd16384);
    set_reg(REG_CELL_SIZE, 32'd1);
    set_reg(REG_CELL_RECIP, 32'd1);
    settings++;
    @(posedge clk);
    set_idling(10, 10);
    queue_pose(FUNC_W2M, 32'sh80000000, 32'sh7FFFFFFF, 16'sd0);
    queue_pose(FUNC_M2W, -32'sd1, 32'sh0, 16'sd25735);
    queue_pose(FUNC_W2M, 32'sd1, 32'sh7FFFFFFF, -16'sd25736);
    queue_pose(FUNC_M2W, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sd1);
    wait_drain();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) begin
        set_reg(REG_ORIGIN_X, 32'h7FFFFFFF);
        set_reg(REG_ORIGIN_Y, 32'h80000000);
        set_reg(REG_MAP_ANGLE, -32'sd25736);
        set_reg(REG_COS_ANGLE, 32'sd16384);
        set_reg(REG_SIN_ANGLE, -32'sd16384);
        set_reg(REG_CELL_SIZE, 32'h7FFFFFFF);
        set_reg(REG_CELL_RECIP, 32'h7FFFFFFF);
      end else begin
        set_reg(REG_ORIGIN_X, rand_coord());
        set_reg(REG_ORIGIN_Y, rand_coord());
        set_reg(REG_MAP_ANGLE, int'($urandom_range(51472)) - 25736);
        set_reg(REG_COS_ANGLE, int'($urandom_range(32768)) - 16384);
        set_reg(REG_SIN_ANGLE, int'($urandom_range(32768)) - 16384);
        set_reg(REG_CELL_SIZE, CFG_DATA_W'(rand_scale()));
        set_reg(REG_CELL_RECIP, CFG_DATA_W'(rand_scale()));
      end
      settings++;
      @(posedge clk);
      case (ph % 4)
        0: set_idling(0, 0);
        1: set_idling(88, 0);
        2: set_idling(0, 88);
        default: set_idling(10, 10);
      endcase
      for (k = 0; k < PHASE_POSES; k++) begin
        // hold off the sender until the pipe is empty
        if (k == PHASE_POSES / 2) begin
          wait_drain();
          @(posedge clk);
        end
        queue_pose(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_heading());
      end
      wait_drain();
    end

    set_idling(0, 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_poses.size() != 0) begin
      $display("%0d transactions never arrived", expected_poses.size());
      mismatches += expected_poses.size();
    end
    $display("checked %0d poses in both directions over %0d register settings", poses_checked,
             settings);
    $display("idling patterns: none, sender idle, receiver stall, both; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
